// ===== hw/rtl/clb_pkg.sv =====
// ----------------------------------------------------------------------------
// clb_pkg: shared types and constants for the line-edit buffer
// Command codes, cell entry and control types, and the two-set jamo table.
// ----------------------------------------------------------------------------
package clb_pkg;

   // default number of cells in the chain
   localparam int DEPTH_DEFAULT = 64;

   // command codes carried by req_opcode
   typedef enum logic [2:0] {
      OP_LEFT   = 3'd0,
      OP_RIGHT  = 3'd1,
      OP_INSERT = 3'd2,
      OP_TOGGLE = 3'd3,
      OP_BKSP   = 3'd4,
      OP_READ   = 3'd5
   } opcode_type;

   // character constants
   localparam logic [7:0] CH_UNDERSCORE = 8'h5F;
   localparam logic [7:0] CH_SPACE      = 8'h20;
   localparam logic [7:0] CH_LOWER_A    = 8'h61;
   localparam logic [7:0] CH_LOWER_Z    = 8'h7A;
   localparam logic [7:0] CH_UPPER_A    = 8'h41;
   localparam logic [7:0] CH_UPPER_Z    = 8'h5A;

   // one stored entry: character and language stamp
   typedef struct packed {
      logic [7:0] char_code;
      logic       korean;
   } entry_type;

   // where a cell takes its next entry from
   typedef enum logic [1:0] {
      SEL_HOLD,
      SEL_PREV,
      SEL_NEXT,
      SEL_LOAD
   } cell_sel_type;

   // control of one result beat handed to the output stage
   typedef struct packed {
      logic valid;
      logic last;
      logic empty;
   } rsp_ctl_type;

   // map a letter index (a..z) to its compatibility jamo code point
   function automatic logic [15:0] jamo_of_letter(input logic [4:0] idx);
      logic [15:0] cp;
      case (idx)
         5'd0:    cp = 16'h3141;
         5'd1:    cp = 16'h3160;
         5'd2:    cp = 16'h314A;
         5'd3:    cp = 16'h3147;
         5'd4:    cp = 16'h3137;
         5'd5:    cp = 16'h3139;
         5'd6:    cp = 16'h314E;
         5'd7:    cp = 16'h3157;
         5'd8:    cp = 16'h3151;
         5'd9:    cp = 16'h3153;
         5'd10:   cp = 16'h314F;
         5'd11:   cp = 16'h3163;
         5'd12:   cp = 16'h3161;
         5'd13:   cp = 16'h315C;
         5'd14:   cp = 16'h3150;
         5'd15:   cp = 16'h3154;
         5'd16:   cp = 16'h3142;
         5'd17:   cp = 16'h3131;
         5'd18:   cp = 16'h3134;
         5'd19:   cp = 16'h3145;
         5'd20:   cp = 16'h3155;
         5'd21:   cp = 16'h314D;
         5'd22:   cp = 16'h3148;
         5'd23:   cp = 16'h314C;
         5'd24:   cp = 16'h315B;
         5'd25:   cp = 16'h314B;
         default: cp = 16'h0000;
      endcase
      return cp;
   endfunction

endpackage

// ===== hw/rtl/clb_cell.sv =====
// ----------------------------------------------------------------------------
// clb_cell: one position of the edit chain
// Holds one entry and takes the next one from its left or right neighbor,
// from the load bus, or keeps it.
// ----------------------------------------------------------------------------
module clb_cell (
   input  logic                  clock,
   input  clb_pkg::cell_sel_type sel,
   input  clb_pkg::entry_type    prev_entry,
   input  clb_pkg::entry_type    next_entry,
   input  clb_pkg::entry_type    load_entry,
   output clb_pkg::entry_type    entry
);
   import clb_pkg::*;

   entry_type entry_ff;
   entry_type entry_in;

   // pick the source of the next entry
   always_comb begin
      case (sel)
         SEL_PREV: entry_in = prev_entry;
         SEL_NEXT: entry_in = next_entry;
         SEL_LOAD: entry_in = load_entry;
         default:  entry_in = entry_ff;
      endcase
   end

   // hold the entry
   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign entry = entry_ff;

endmodule

// ===== hw/rtl/clb_map.sv =====
// ----------------------------------------------------------------------------
// clb_map: result stage
// Turns the head entry into a code point and visibility, and registers the
// result beat.
// ----------------------------------------------------------------------------
module clb_map (
   input  logic                 clock,
   input  logic                 reset,
   input  clb_pkg::rsp_ctl_type ctl,
   input  clb_pkg::entry_type   head,
   output logic                 rsp_strobe,
   output logic [15:0]          rsp_code_point,
   output logic                 rsp_visible,
   output logic                 rsp_last,
   output logic                 rsp_buffer_empty
);
   import clb_pkg::*;

   logic        strobe_ff;
   logic [15:0] code_ff;
   logic        visible_ff;
   logic        last_ff;
   logic        empty_ff;
   logic [15:0] code_in;
   logic        visible_in;
   logic        is_lower;
   logic        is_upper;
   logic [7:0]  letter_off;

   // classify the character
   assign is_lower = (head.char_code >= CH_LOWER_A) && (head.char_code <= CH_LOWER_Z);
   assign is_upper = (head.char_code >= CH_UPPER_A) && (head.char_code <= CH_UPPER_Z);
   assign letter_off = is_lower ? (head.char_code - CH_LOWER_A)
                                : (head.char_code - CH_UPPER_A);

   // map English bytes through, Korean letters to jamo, drop the rest
   always_comb begin
      if (ctl.empty) begin
         code_in    = 16'h0000;
         visible_in = 1'b0;
      end else if (!head.korean) begin
         code_in    = {8'h00, head.char_code};
         visible_in = 1'b1;
      end else if (is_lower || is_upper) begin
         code_in    = jamo_of_letter(letter_off[4:0]);
         visible_in = 1'b1;
      end else begin
         code_in    = 16'h0000;
         visible_in = 1'b0;
      end
   end

   // register the strobe
   always_ff @(posedge clock) begin
      if (reset) begin
         strobe_ff <= 1'b0;
      end else begin
         strobe_ff <= ctl.valid;
      end
   end

   // register the result payload
   always_ff @(posedge clock) begin
      code_ff    <= code_in;
      visible_ff <= visible_in;
      last_ff    <= ctl.last;
      empty_ff   <= ctl.empty;
   end

   assign rsp_strobe       = strobe_ff;
   assign rsp_code_point   = code_ff;
   assign rsp_visible      = visible_ff;
   assign rsp_last         = last_ff;
   assign rsp_buffer_empty = empty_ff;

endmodule

// ===== hw/rtl/cursor_line_edit_buffer_top.sv =====
// ----------------------------------------------------------------------------
// cursor_line_edit_buffer_top: line-edit buffer with a cursor
// Entries live in a chain of cells; edits shift the chain, read out rotates it.
//
//   channel   ports                               handshake
//   command   req_opcode, req_char_code           start high, busy low
//   result    rsp_code_point, rsp_visible,        rsp_strobe, one cycle,
//             rsp_last, rsp_buffer_empty          always taken
//
// Insert and backspace shift the cells from the cursor to the end of the line.
// Read out holds busy while one beat per cycle is taken from the head cell as
// the occupied cells rotate once around; each beat appears the cycle after.
// An empty read out gives a single beat and does not raise busy.
// Reset clears the fill count, cursor and mode; cell contents stay unknown.
// ----------------------------------------------------------------------------
module cursor_line_edit_buffer_top #(
   parameter int DEPTH = clb_pkg::DEPTH_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [2:0]  req_opcode,
   input  logic [7:0]  req_char_code,
   output logic        rsp_strobe,
   output logic [15:0] rsp_code_point,
   output logic        rsp_visible,
   output logic        rsp_last,
   output logic        rsp_buffer_empty
);
   import clb_pkg::*;

   localparam int CW = $clog2(DEPTH + 1);

   typedef enum logic {
      ST_IDLE,
      ST_READ
   } state_type;

   state_type   state_ff, state_in;
   logic [CW-1:0] fill_ff, fill_in;
   logic [CW-1:0] cursor_ff, cursor_in;
   logic [CW-1:0] rd_cnt_ff, rd_cnt_in;
   logic          korean_ff, korean_in;

   logic        cmd_go;
   logic        do_ins;
   logic        do_bksp;
   logic        do_rot;
   logic        rd_last;
   rsp_ctl_type ctl;
   entry_type   load_entry;
   entry_type   cell_q [DEPTH];

   assign cmd_go  = start && !busy;
   assign rd_last = (CW'(rd_cnt_ff + 1'b1) == fill_ff);

   // decode commands and advance the controller
   always_comb begin
      state_in  = state_ff;
      fill_in   = fill_ff;
      cursor_in = cursor_ff;
      rd_cnt_in = rd_cnt_ff;
      korean_in = korean_ff;
      do_ins    = 1'b0;
      do_bksp   = 1'b0;
      do_rot    = 1'b0;
      ctl       = '0;
      if (state_ff == ST_READ) begin
         do_rot    = 1'b1;
         ctl.valid = 1'b1;
         ctl.last  = rd_last;
         rd_cnt_in = CW'(rd_cnt_ff + 1'b1);
         if (rd_last) begin
            state_in = ST_IDLE;
         end
      end else if (cmd_go) begin
         case (opcode_type'(req_opcode))
            OP_LEFT: begin
               if (cursor_ff != '0) begin
                  cursor_in = cursor_ff - 1'b1;
               end
            end
            OP_RIGHT: begin
               if (cursor_ff != fill_ff) begin
                  cursor_in = cursor_ff + 1'b1;
               end
            end
            OP_INSERT: begin
               if (fill_ff < CW'(DEPTH)) begin
                  do_ins    = 1'b1;
                  fill_in   = fill_ff + 1'b1;
                  cursor_in = cursor_ff + 1'b1;
               end
            end
            OP_TOGGLE: begin
               korean_in = !korean_ff;
            end
            OP_BKSP: begin
               if (cursor_ff != '0) begin
                  do_bksp   = 1'b1;
                  fill_in   = fill_ff - 1'b1;
                  cursor_in = cursor_ff - 1'b1;
               end
            end
            OP_READ: begin
               if (fill_ff == '0) begin
                  ctl.valid = 1'b1;
                  ctl.last  = 1'b1;
                  ctl.empty = 1'b1;
               end else begin
                  state_in  = ST_READ;
                  rd_cnt_in = '0;
               end
            end
            default: begin
            end
         endcase
      end
   end

   // hold controller state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         fill_ff   <= '0;
         cursor_ff <= '0;
         rd_cnt_ff <= '0;
         korean_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         fill_ff   <= fill_in;
         cursor_ff <= cursor_in;
         rd_cnt_ff <= rd_cnt_in;
         korean_ff <= korean_in;
      end
   end

   assign busy = (state_ff == ST_READ);

   // load bus: new character on insert, head entry while rotating
   always_comb begin
      if (do_rot) begin
         load_entry = cell_q[0];
      end else begin
         load_entry.char_code = (req_char_code == CH_UNDERSCORE) ? CH_SPACE : req_char_code;
         load_entry.korean    = korean_ff;
      end
   end

   // build the chain of cells
   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      cell_sel_type sel;
      entry_type    prev_e;
      entry_type    next_e;

      always_comb begin
         sel = SEL_HOLD;
         if (do_ins) begin
            if (CW'(i) == cursor_ff) begin
               sel = SEL_LOAD;
            end else if ((CW'(i) > cursor_ff) && (CW'(i) <= fill_ff)) begin
               sel = SEL_PREV;
            end
         end else if (do_bksp) begin
            if ((CW'(i + 1) >= cursor_ff) && (CW'(i + 1) < fill_ff)) begin
               sel = SEL_NEXT;
            end
         end else if (do_rot) begin
            if (CW'(i + 1) < fill_ff) begin
               sel = SEL_NEXT;
            end else if (CW'(i + 1) == fill_ff) begin
               sel = SEL_LOAD;
            end
         end
      end

      if (i == 0) begin : g_head
         assign prev_e = load_entry;
      end else begin : g_body
         assign prev_e = cell_q[i-1];
      end

      if (i == DEPTH - 1) begin : g_tail
         assign next_e = cell_q[0];
      end else begin : g_inner
         assign next_e = cell_q[i+1];
      end

      clb_cell u_cell (
         .clock      (clock),
         .sel        (sel),
         .prev_entry (prev_e),
         .next_entry (next_e),
         .load_entry (load_entry),
         .entry      (cell_q[i])
      );
   end

   // result stage
   clb_map u_map (
      .clock            (clock),
      .reset            (reset),
      .ctl              (ctl),
      .head             (cell_q[0]),
      .rsp_strobe       (rsp_strobe),
      .rsp_code_point   (rsp_code_point),
      .rsp_visible      (rsp_visible),
      .rsp_last         (rsp_last),
      .rsp_buffer_empty (rsp_buffer_empty)
   );

   // cursor never passes the end of the line
   a_cursor_in_range: assert property (@(posedge clock) disable iff (reset)
      cursor_ff <= fill_ff)
      else $error("cursor beyond fill count");

   // fill count stays within the chain
   a_fill_in_range: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= CW'(DEPTH))
      else $error("fill count beyond depth");

   // a rotating read out always has entries to stream
   a_read_nonempty: assert property (@(posedge clock) disable iff (reset)
      busy |-> (fill_ff != '0) && (rd_cnt_ff < fill_ff))
      else $error("read out over an empty chain");

   // an empty beat is the only beat of its read out
   a_empty_is_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_buffer_empty) |-> rsp_last)
      else $error("empty beat without last");

endmodule
